### design/bct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bct_pkg;

  // t is unsigned Q0.16 with one extra bit so that t = 1.0 is representable
  localparam int T_FRAC = 16;
  localparam int T_W    = T_FRAC + 1;
  localparam int T_HALF = 1 << (T_FRAC - 1);

  localparam int NUM_COORDS = 8;

  // curve order carried by the command field
  localparam logic CMD_QUAD  = 1'b0;
  localparam logic CMD_CUBIC = 1'b1;

  typedef struct packed {
    logic           vld;
    logic           cubic;
    logic           first;
    logic           last;
    logic [T_W-1:0] t;
  } bct_ctl_t;

endpackage
`default_nettype wire

### design/bct_lerp.sv
`timescale 1ns / 1ps
`default_nettype none
// y = a + (((b - a) * t + half) >>> 16), exact b at t = 1
module bct_lerp #(
  parameter int CW = 16
) (
  input  wire logic signed [CW-1:0]          a,
  input  wire logic signed [CW-1:0]          b,
  input  wire logic [bct_pkg::T_W-1:0]       t,
  output logic signed [CW-1:0]               y
);

  localparam int PW = CW + bct_pkg::T_W + 2;

  logic signed [CW:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [CW:0]   sum;

  always_comb begin
    diff = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
    prod = PW'(diff) * $signed({{(PW - bct_pkg::T_W){1'b0}}, t});
    rnd  = (prod + PW'(bct_pkg::T_HALF)) >>> bct_pkg::T_FRAC;
    // the interpolant stays within [a, b], so the quotient fits CW+1 bits
    sum  = $signed({a[CW-1], a}) + rnd[CW:0];
    y    = sum[CW-1:0];
  end

endmodule
`default_nettype wire

### design/bct_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// Latches one curve and issues its steps k = 1..STEPS, one per advance.
module bct_seq #(
  parameter int STEPS = 20,
  parameter int CW    = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          adv,
  input  wire logic                                          in_valid,
  output logic                                               in_ready,
  input  wire logic                                          cmd,
  input  wire logic [bct_pkg::NUM_COORDS-1:0][CW-1:0]        pts_in,
  output logic [bct_pkg::NUM_COORDS-1:0][CW-1:0]             pts,
  output bct_pkg::bct_ctl_t                                  ctl
);

  localparam int KW = $clog2(STEPS + 1);

  logic [bct_pkg::T_W-1:0] t_tab [2**KW];

  for (genvar g = 0; g < 2**KW; g++) begin : g_tab
    localparam int TV = (g <= STEPS) ?
                        ((g * (1 << bct_pkg::T_FRAC)) + STEPS / 2) / STEPS : 0;
    assign t_tab[g] = bct_pkg::T_W'(TV);
  end

  logic [bct_pkg::NUM_COORDS-1:0][CW-1:0] cs_r;
  logic                                   cubic_r;
  logic                                   busy_r;
  logic [KW-1:0]                          k_r;
  logic [bct_pkg::T_W-1:0]                t_r;
  logic                                   at_last;
  logic                                   load;

  assign at_last  = (k_r == KW'(STEPS));
  assign in_ready = !busy_r || (adv && at_last);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= KW'(1);
    end else if (load) begin
      busy_r <= 1'b1;
      k_r    <= KW'(1);
    end else if (adv && busy_r) begin
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        k_r <= k_r + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cs_r    <= pts_in;
      cubic_r <= (cmd == bct_pkg::CMD_CUBIC);
      t_r     <= t_tab[1];
    end else if (adv && busy_r && !at_last) begin
      t_r <= t_tab[k_r + KW'(1)];
    end
  end

  assign pts       = cs_r;
  assign ctl.vld   = busy_r;
  assign ctl.cubic = cubic_r;
  assign ctl.first = (k_r == KW'(1));
  assign ctl.last  = at_last;
  assign ctl.t     = t_r;

endmodule
`default_nettype wire

### design/bct_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// First two de Casteljau levels, one register stage each.
module bct_eval #(
  parameter int CW = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     adv,
  input  wire bct_pkg::bct_ctl_t                        ctl_in,
  input  wire logic [bct_pkg::NUM_COORDS-1:0][CW-1:0]   pts,
  output bct_pkg::bct_ctl_t                             ctl_out,
  output logic [1:0][CW-1:0]                            d,
  output logic [1:0][CW-1:0]                            e,
  output logic [1:0][CW-1:0]                            p0
);

  bct_pkg::bct_ctl_t  s1_ctl_r;
  logic [1:0][CW-1:0] s1_a_r, s1_b_r, s1_c_r, s1_p0_r;
  logic [1:0][CW-1:0] l1_a, l1_b, l1_c;

  bct_pkg::bct_ctl_t  s2_ctl_r;
  logic [1:0][CW-1:0] s2_d_r, s2_e_r, s2_p0_r;
  logic [1:0][CW-1:0] l2_d, l2_e;

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    bct_lerp #(.CW(CW)) u_l1a (
      .a(pts[ax]), .b(pts[2 + ax]), .t(ctl_in.t), .y(l1_a[ax])
    );
    bct_lerp #(.CW(CW)) u_l1b (
      .a(pts[2 + ax]), .b(pts[4 + ax]), .t(ctl_in.t), .y(l1_b[ax])
    );
    bct_lerp #(.CW(CW)) u_l1c (
      .a(pts[4 + ax]), .b(pts[6 + ax]), .t(ctl_in.t), .y(l1_c[ax])
    );
    bct_lerp #(.CW(CW)) u_l2d (
      .a(s1_a_r[ax]), .b(s1_b_r[ax]), .t(s1_ctl_r.t), .y(l2_d[ax])
    );
    bct_lerp #(.CW(CW)) u_l2e (
      .a(s1_b_r[ax]), .b(s1_c_r[ax]), .t(s1_ctl_r.t), .y(l2_e[ax])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= ctl_in;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r  <= l1_a;
      s1_b_r  <= l1_b;
      s1_c_r  <= l1_c;
      s1_p0_r <= pts[1:0];
      s2_d_r  <= l2_d;
      s2_e_r  <= l2_e;
      s2_p0_r <= s1_p0_r;
    end
  end

  assign ctl_out = s2_ctl_r;
  assign d       = s2_d_r;
  assign e       = s2_e_r;
  assign p0      = s2_p0_r;

endmodule
`default_nettype wire

### design/bezier_curve_tessellator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Bezier flattener: each input word (quadratic or cubic, signed Q12.4 control
// points) yields STEPS line segment words, evaluated by de Casteljau at
// t = k/STEPS with round-to-nearest lerps, the last one flagged. The step
// sequencer issues one segment per cycle while the output is not stalled, and
// the next curve is taken in the cycle its last step issues; a segment leaves
// through the two evaluation registers and the output register, one lerp level
// per stage. A stalled output holds the whole pipeline; a new curve is still
// latched while the sequencer is free.
module bezier_curve_tessellator_top #(
  parameter int STEPS      = 20,
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_command,
  input  wire logic signed [COORD_BITS-1:0] in_p0_x,
  input  wire logic signed [COORD_BITS-1:0] in_p0_y,
  input  wire logic signed [COORD_BITS-1:0] in_p1_x,
  input  wire logic signed [COORD_BITS-1:0] in_p1_y,
  input  wire logic signed [COORD_BITS-1:0] in_p2_x,
  input  wire logic signed [COORD_BITS-1:0] in_p2_y,
  input  wire logic signed [COORD_BITS-1:0] in_p3_x,
  input  wire logic signed [COORD_BITS-1:0] in_p3_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [COORD_BITS-1:0]      out_seg_start_x,
  output logic signed [COORD_BITS-1:0]      out_seg_start_y,
  output logic signed [COORD_BITS-1:0]      out_seg_end_x,
  output logic signed [COORD_BITS-1:0]      out_seg_end_y,
  output logic                              out_last_segment
);

  localparam int CW = COORD_BITS;

  logic                                   adv;
  logic [bct_pkg::NUM_COORDS-1:0][CW-1:0] pts_in, pts;
  bct_pkg::bct_ctl_t                      seq_ctl, s2_ctl;
  logic [1:0][CW-1:0]                     d, e, p0, l3, fin;

  logic                                   out_valid_r;
  logic [1:0][CW-1:0]                     out_start_r, out_end_r;
  logic                                   out_last_r;

  assign adv    = !out_valid_r || out_ready;
  assign pts_in = {in_p3_y, in_p3_x, in_p2_y, in_p2_x,
                   in_p1_y, in_p1_x, in_p0_y, in_p0_x};

  bct_seq #(.STEPS(STEPS), .CW(CW)) u_seq (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(in_command), .pts_in(pts_in), .pts(pts), .ctl(seq_ctl)
  );

  bct_eval #(.CW(CW)) u_eval (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .ctl_in(seq_ctl), .pts(pts),
    .ctl_out(s2_ctl), .d(d), .e(e), .p0(p0)
  );

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    bct_lerp #(.CW(CW)) u_l3 (
      .a(d[ax]), .b(e[ax]), .t(s2_ctl.t), .y(l3[ax])
    );
    // quadratic curves finish at the second level
    assign fin[ax] = s2_ctl.cubic ? l3[ax] : d[ax];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_ctl.vld;
    end
  end

  // segments of a curve arrive in order, so the held end is the next start
  always_ff @(posedge clk) begin
    if (adv && s2_ctl.vld) begin
      out_start_r <= s2_ctl.first ? p0 : out_end_r;
      out_end_r   <= fin;
      out_last_r  <= s2_ctl.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_seg_start_x  = out_start_r[0];
  assign out_seg_start_y  = out_start_r[1];
  assign out_seg_end_x    = out_end_r[0];
  assign out_seg_end_y    = out_end_r[1];
  assign out_last_segment = out_last_r;

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int STEPS      = 20;
  localparam int COORD_BITS = 16;
  localparam int NUM_ITEMS  = 370;
  localparam int LONG_HOLD  = 200;
  localparam int HOLD_AT    = 2000;
  localparam int DRAIN_AT   = 260;
  localparam int TAIL       = 20;
  localparam int LIMIT      = 1000000;

  typedef struct packed {
    logic                                          cubic;
    logic [bct_pkg::NUM_COORDS-1:0][COORD_BITS-1:0] p;
  } curve_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
    logic                         last;
  } segment_t;

  // Flattens each accepted curve into the segments it must produce and
  // checks the outgoing segment words against them in order.
  class flatten_tracker;
    segment_t due_segments[$];
    int       errors;
    int       curves_seen;
    int       cubic_seen;
    int       segs_seen;

    function new();
      errors      = 0;
      curves_seen = 0;
      cubic_seen  = 0;
      segs_seen   = 0;
    endfunction

    task flag_mismatch(string msg);
      errors++;
      $display("[%0t] segment %0d: %s", $realtime, segs_seen, msg);
    endtask

    // a + round((b - a) * t), floor shift after the half bias
    function longint blend(longint a, longint b, longint t);
      return a + (((b - a) * t + bct_pkg::T_HALF) >>> bct_pkg::T_FRAC);
    endfunction

    function int due_count();
      return due_segments.size();
    endfunction

    function void flatten_curve(curve_t c);
      longint   q [bct_pkg::NUM_COORDS];
      longint   tk, a, b, cc, d, e;
      longint   prev [2];
      longint   pt [2];
      segment_t s;
      for (int i = 0; i < bct_pkg::NUM_COORDS; i++) q[i] = longint'($signed(c.p[i]));
      curves_seen++;
      if (c.cubic == bct_pkg::CMD_CUBIC) cubic_seen++;
      prev[0] = q[0];
      prev[1] = q[1];
      for (int k = 1; k <= STEPS; k++) begin
        tk = ((longint'(k) << bct_pkg::T_FRAC) + STEPS / 2) / STEPS;
        for (int ax = 0; ax < 2; ax++) begin
          a = blend(q[ax], q[2 + ax], tk);
          b = blend(q[2 + ax], q[4 + ax], tk);
          if (c.cubic == bct_pkg::CMD_CUBIC) begin
            cc = blend(q[4 + ax], q[6 + ax], tk);
            d  = blend(a, b, tk);
            e  = blend(b, cc, tk);
            pt[ax] = blend(d, e, tk);
          end else begin
            pt[ax] = blend(a, b, tk);
          end
        end
        s.sx   = prev[0][COORD_BITS-1:0];
        s.sy   = prev[1][COORD_BITS-1:0];
        s.ex   = pt[0][COORD_BITS-1:0];
        s.ey   = pt[1][COORD_BITS-1:0];
        s.last = (k == STEPS);
        due_segments.insert(due_segments.size(), s);
        prev = pt;
      end
    endfunction

    task take_segment(segment_t got);
      segment_t want;
      segs_seen++;
      if (due_segments.size() == 0) begin
        flag_mismatch($sformatf("unexpected segment (%0d,%0d)->(%0d,%0d)",
                                got.sx, got.sy, got.ex, got.ey));
        return;
      end
      want = due_segments.pop_front();
      if (got.sx !== want.sx)
        flag_mismatch($sformatf("start_x got %0d want %0d", got.sx, want.sx));
      if (got.sy !== want.sy)
        flag_mismatch($sformatf("start_y got %0d want %0d", got.sy, want.sy));
      if (got.ex !== want.ex)
        flag_mismatch($sformatf("end_x got %0d want %0d", got.ex, want.ex));
      if (got.ey !== want.ey)
        flag_mismatch($sformatf("end_y got %0d want %0d", got.ey, want.ey));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last_segment got %0b want %0b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_command;
  logic signed [COORD_BITS-1:0] in_p0_x, in_p0_y, in_p1_x, in_p1_y;
  logic signed [COORD_BITS-1:0] in_p2_x, in_p2_y, in_p3_x, in_p3_y;
  logic out_valid;
  logic out_ready;
  logic signed [COORD_BITS-1:0] out_seg_start_x, out_seg_start_y;
  logic signed [COORD_BITS-1:0] out_seg_end_x, out_seg_end_y;
  logic out_last_segment;

  flatten_tracker fl;
  curve_t dir_q[$];
  int cycles;
  int in_block_run;
  int in_block_max;

  bezier_curve_tessellator_top #(
    .STEPS     (STEPS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_p0_x         (in_p0_x),
    .in_p0_y         (in_p0_y),
    .in_p1_x         (in_p1_x),
    .in_p1_y         (in_p1_y),
    .in_p2_x         (in_p2_x),
    .in_p2_y         (in_p2_y),
    .in_p3_x         (in_p3_x),
    .in_p3_y         (in_p3_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seg_start_x (out_seg_start_x),
    .out_seg_start_y (out_seg_start_y),
    .out_seg_end_x   (out_seg_end_x),
    .out_seg_end_y   (out_seg_end_y),
    .out_last_segment(out_last_segment)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d segments outstanding", cycles, fl.due_count());
      $display("Mismatches found");
      $finish;
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    curve_t   c;
    segment_t s;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        c.cubic = in_command;
        c.p     = {in_p3_y, in_p3_x, in_p2_y, in_p2_x, in_p1_y, in_p1_x, in_p0_y, in_p0_x};
        fl.flatten_curve(c);
      end
      if (in_valid && !in_ready) begin
        in_block_run++;
        if (in_block_run > in_block_max) in_block_max = in_block_run;
      end else begin
        in_block_run = 0;
      end
      if (out_valid && out_ready) begin
        s = {out_seg_start_x, out_seg_start_y, out_seg_end_x, out_seg_end_y, out_last_segment};
        fl.take_segment(s);
      end
    end
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic curve_t curve_of(logic cmd, int x0, int y0, int x1, int y1,
                                      int x2, int y2, int x3, int y3);
    curve_t c;
    c.cubic = cmd;
    c.p     = {y3[COORD_BITS-1:0], x3[COORD_BITS-1:0], y2[COORD_BITS-1:0],
               x2[COORD_BITS-1:0], y1[COORD_BITS-1:0], x1[COORD_BITS-1:0],
               y0[COORD_BITS-1:0], x0[COORD_BITS-1:0]};
    return c;
  endfunction

  function automatic void note_dir(curve_t c);
    dir_q.insert(dir_q.size(), c);
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    int     kind, bx, by, src, dst;
    kind    = $urandom_range(0, 9);
    c.cubic = 1'($urandom_range(0, 1));
    for (int i = 0; i < bct_pkg::NUM_COORDS; i++) c.p[i] = COORD_BITS'($urandom);
    case (kind)
      6, 7: begin
        // tight cluster, the usual shape of a glyph or a stroke
        bx = int'($urandom_range(0, 60000)) - 30000;
        by = int'($urandom_range(0, 60000)) - 30000;
        for (int i = 0; i < bct_pkg::NUM_COORDS; i += 2) begin
          c.p[i]     = COORD_BITS'(bx + int'($urandom_range(0, 1023)) - 512);
          c.p[i + 1] = COORD_BITS'(by + int'($urandom_range(0, 1023)) - 512);
        end
      end
      8: begin
        // coincident control points
        for (int n = 0; n < 2; n++) begin
          src = $urandom_range(0, 3);
          dst = $urandom_range(0, 3);
          c.p[2 * dst]     = c.p[2 * src];
          c.p[2 * dst + 1] = c.p[2 * src + 1];
        end
      end
      9: begin
        for (int i = 0; i < bct_pkg::NUM_COORDS; i++) begin
          case ($urandom_range(0, 3))
            0: c.p[i] = 16'h8000;
            1: c.p[i] = 16'h7fff;
            2: c.p[i] = 16'h0000;
            default: c.p[i] = 16'hffff;
          endcase
        end
      end
      default: ;
    endcase
    return c;
  endfunction

  // called at a falling edge; returns at a falling edge with valid still up
  // when no gap follows
  task drive_curve(curve_t c, int gap);
    in_command = c.cubic;
    in_p0_x    = c.p[0];
    in_p0_y    = c.p[1];
    in_p1_x    = c.p[2];
    in_p1_y    = c.p[3];
    in_p2_x    = c.p[4];
    in_p2_y    = c.p[5];
    in_p3_x    = c.p[6];
    in_p3_y    = c.p[7];
    in_valid   = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task wait_drained();
    in_valid = 1'b0;
    while (fl.due_count() != 0) @(negedge clk);
  endtask

  // output side: random stalls, quiet stretches, and one long hold-off
  initial begin : sink
    int stall;
    int quiet;
    bit held;
    stall     = 0;
    quiet     = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && fl.segs_seen >= HOLD_AT) begin
        out_ready = 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) @(negedge clk);
        held = 1'b1;
      end
      if (quiet > 0) begin
        out_ready = 1'b1;
        quiet--;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        case ($urandom_range(0, 19))
          0: quiet = $urandom_range(50, 150);
          1, 2, 3, 4, 5, 6: stall = pick_gap();
          default: ;
        endcase
      end
    end
  end

  initial begin : stim
    int     sent;
    fl           = new();
    cycles       = 0;
    in_block_run = 0;
    in_block_max = 0;
    in_valid     = 1'b0;
    in_command   = bct_pkg::CMD_QUAD;
    in_p0_x = '0; in_p0_y = '0; in_p1_x = '0; in_p1_y = '0;
    in_p2_x = '0; in_p2_y = '0; in_p3_x = '0; in_p3_y = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    note_dir(curve_of(bct_pkg::CMD_QUAD, 0, 0, 0, 0, 0, 0, 0, 0));
    note_dir(curve_of(bct_pkg::CMD_CUBIC, 0, 0, 0, 0, 0, 0, 0, 0));
    note_dir(curve_of(bct_pkg::CMD_QUAD, 32767, 32767, 32767, 32767, 32767, 32767,
                      32767, 32767));
    note_dir(curve_of(bct_pkg::CMD_CUBIC, -32768, -32768, -32768, -32768, -32768,
                      -32768, -32768, -32768));
    // widest swings, both directions
    note_dir(curve_of(bct_pkg::CMD_QUAD, -32768, -32768, 32767, 32767, -32768, -32768,
                      32767, 32767));
    note_dir(curve_of(bct_pkg::CMD_CUBIC, -32768, 32767, 32767, -32768, -32768, 32767,
                      32767, -32768));
    note_dir(curve_of(bct_pkg::CMD_CUBIC, -32768, -32768, 32767, 32767, 32767, 32767,
                      -32768, -32768));
    note_dir(curve_of(bct_pkg::CMD_CUBIC, 32767, -32768, -32768, 32767, 32767, -32768,
                      -32768, 32767));
    // straight line, p3 junk that a quadratic must ignore
    note_dir(curve_of(bct_pkg::CMD_QUAD, 0, 0, 160, 160, 320, 320, -32768, 32767));
    note_dir(curve_of(bct_pkg::CMD_QUAD, 0, 0, 160, 160, 320, 320, 32767, -32768));
    // coincident points
    note_dir(curve_of(bct_pkg::CMD_QUAD, 100, -50, 100, -50, -300, 700, 5, 5));
    note_dir(curve_of(bct_pkg::CMD_CUBIC, -16, 48, 900, 900, 900, 900, 2000, -7));
    note_dir(curve_of(bct_pkg::CMD_CUBIC, 1000, 1000, -4000, 3000, 6000, -2500,
                      1000, 1000));
    note_dir(curve_of(bct_pkg::CMD_CUBIC, 1234, -4321, 1234, -4321, 1234, -4321,
                      1234, -4321));
    // one-LSB swings stress the rounding
    note_dir(curve_of(bct_pkg::CMD_QUAD, 0, 0, 1, 1, -1, -1, 0, 0));
    note_dir(curve_of(bct_pkg::CMD_CUBIC, 1, 0, 0, 1, -1, 0, 0, -1));
    note_dir(curve_of(bct_pkg::CMD_QUAD, -32768, 0, 32767, 0, -32768, 0, 0, 0));
    note_dir(curve_of(bct_pkg::CMD_CUBIC, 0, -32768, 0, 32767, 0, -32768, 0, 32767));
    foreach (dir_q[i]) drive_curve(dir_q[i], (i % 3 == 0) ? pick_gap() : 0);
    sent = dir_q.size();

    wait_drained();
    @(negedge clk);

    while (sent < NUM_ITEMS) begin
      drive_curve(random_curve(), pick_gap());
      sent++;
      if (sent == DRAIN_AT) wait_drained();
    end
    in_valid = 1'b0;

    wait_drained();
    repeat (TAIL) @(negedge clk);

    $display("flattened %0d curves (%0d cubic) into %0d segments",
             fl.curves_seen, fl.cubic_seen, fl.segs_seen);
    $display("longest input back-pressure %0d cycles, %0d cycles in all",
             in_block_max, cycles);
    if (fl.errors == 0 && fl.due_count() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### files.f
design/bct_pkg.sv
design/bct_lerp.sv
design/bct_seq.sv
design/bct_eval.sv
design/bezier_curve_tessellator_top.sv
sim/tb.sv
